@@ hdl/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared widths, reset values, register indexes, character codes and the
// pixel pair helper of the text console.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int FONT_BYTES_DEF = 8192;
   localparam int MAX_ROWS_DEF   = 32;

   localparam int XY_W       = 13;
   localparam int SCAN_W     = 15;
   localparam int GH_W       = 6;
   localparam int COLOR_W    = 32;
   localparam int OFF_W      = 26;
   localparam int PIX_W      = 64;
   localparam int CODE_W     = 8;
   localparam int FADDR_W    = 13;
   localparam int BYTE_W     = 8;
   localparam int ROWS_W     = 6;
   localparam int FULL_W     = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [XY_W-1:0] XY_MAX = 13'h1FFF;
   localparam int CELL_W = 8;
   localparam int LINE_H = 16;

   localparam logic [XY_W-1:0]    WIDTH_RST  = 13'd640;
   localparam logic [XY_W-1:0]    HEIGHT_RST = 13'd480;
   localparam logic [SCAN_W-1:0]  SCAN_RST   = 15'd2560;
   localparam logic [GH_W-1:0]    GH_RST     = 6'd16;
   localparam logic [COLOR_W-1:0] FG_RST     = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] BG_RST     = 32'h0000_0000;

   localparam logic [CODE_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [CODE_W-1:0] CHAR_BS  = 8'd8;
   localparam logic [CODE_W-1:0] CHAR_LF  = 8'd10;
   localparam logic [CODE_W-1:0] CHAR_CR  = 8'd13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH   = 3'd0,
      CSR_SCREEN_HEIGHT  = 3'd1,
      CSR_SCANLINE_BYTES = 3'd2,
      CSR_GLYPH_HEIGHT   = 3'd3,
      CSR_FG_COLOR       = 3'd4,
      CSR_BG_COLOR       = 3'd5
   } csr_index_type;

   // The left pixel of a pair goes to the low half of the word.
   function automatic logic [PIX_W-1:0] pixel_pair(input logic left_bit,
                                                   input logic right_bit,
                                                   input logic [COLOR_W-1:0] fg,
                                                   input logic [COLOR_W-1:0] bg);
      return {(right_bit ? fg : bg), (left_bit ? fg : bg)};
   endfunction

endpackage

@@ hdl/tcgr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcgr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/text_console_glyph_renderer_unit.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Keeps a pixel cursor, renders bitmap font glyphs row by row into
// framebuffer row transfers and stores font bytes in an internal memory.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one character or one font byte per transfer.
// A font byte write (mode 1) and a control character produce no
// response. A printable character is accepted, then the block places the
// cursor, computes the first row offset and primes the font memory read,
// and then sends one response per glyph row, preceded by a clear-screen
// response when the cursor leaves the bottom edge. The font memory's single
// read port gives one row per cycle while the receiver does not stall.
// The response channel is fed from an output register. When the receiver
// stalls, the row sequence holds and the font memory read address is kept
// until the register drains. Requests are stalled while a character is in
// work. Reset restores the register defaults and homes the cursor; the
// font memory is not cleared and must be loaded before use.
// The configuration port must be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit #(
   parameter int FONT_BYTES     = tcgr_pkg::FONT_BYTES_DEF,
   parameter int MAX_GLYPH_ROWS = tcgr_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [tcgr_pkg::CODE_W-1:0]       req_char_code,
   input  logic [tcgr_pkg::FADDR_W-1:0]      req_font_addr,
   input  logic [tcgr_pkg::BYTE_W-1:0]       req_font_byte,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_clear_screen,
   output logic [tcgr_pkg::OFF_W-1:0]        rsp_row_offset,
   output logic [tcgr_pkg::PIX_W-1:0]        rsp_pixels_01,
   output logic [tcgr_pkg::PIX_W-1:0]        rsp_pixels_23,
   output logic [tcgr_pkg::PIX_W-1:0]        rsp_pixels_45,
   output logic [tcgr_pkg::PIX_W-1:0]        rsp_pixels_67,
   output logic                              rsp_last,

   input  logic                              csr_wr_en,
   input  logic [tcgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   import tcgr_pkg::*;

   localparam int AW = $clog2(FONT_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_FETCH,
      ST_CLEAR,
      ST_ROWS
   } state_type;

   state_type            state_ff;

   logic [XY_W-1:0]      screen_width_ff;
   logic [XY_W-1:0]      screen_height_ff;
   logic [SCAN_W-1:0]    scanline_bytes_ff;
   logic [GH_W-1:0]      glyph_height_ff;
   logic [COLOR_W-1:0]   fg_color_ff;
   logic [COLOR_W-1:0]   bg_color_ff;

   logic [XY_W-1:0]      cursor_x_ff;
   logic [XY_W-1:0]      cursor_y_ff;
   logic [CODE_W-1:0]    code_ff;
   logic                 clear_ff;
   logic [ROWS_W-1:0]    rows_ff;
   logic [ROWS_W-1:0]    row_ff;
   logic [OFF_W-1:0]     off_ff;
   logic [FULL_W-1:0]    base_ff;
   logic                 oor_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_clear_ff;
   logic [OFF_W-1:0]     rsp_offset_ff;
   logic [PIX_W-1:0]     rsp_pix01_ff;
   logic [PIX_W-1:0]     rsp_pix23_ff;
   logic [PIX_W-1:0]     rsp_pix45_ff;
   logic [PIX_W-1:0]     rsp_pix67_ff;
   logic                 rsp_last_ff;

   logic                 req_accept;
   logic                 out_free;
   logic [XY_W:0]        x_plus_in;
   logic                 wrap_in;
   logic [XY_W:0]        y_sum_in;
   logic [XY_W-1:0]      y_down_in;
   logic                 y_clear_in;
   logic [XY_W-1:0]      y_eff_in;
   logic [ROWS_W-1:0]    rows_lim_in;
   logic                 fits_in;
   logic [XY_W-1:0]      x_adv_in;
   logic [OFF_W-1:0]     off_in;
   logic [FULL_W-1:0]    base_in;
   logic [ROWS_W-1:0]    row_in;
   logic                 last_row_in;
   logic [FULL_W-1:0]    rd_full_in;
   logic                 oor_in;
   logic [AW-1:0]        rd_addr;
   logic [BYTE_W-1:0]    rd_data;
   logic [BYTE_W-1:0]    bits_in;
   logic [FULL_W-1:0]    wr_full;
   logic                 wr_en;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      x_plus_in   = {1'b0, cursor_x_ff} + (XY_W+1)'(CELL_W);
      wrap_in     = x_plus_in > {1'b0, screen_width_ff};
      y_sum_in    = {1'b0, cursor_y_ff} + (XY_W+1)'(LINE_H);
      y_down_in   = (y_sum_in > {1'b0, screen_height_ff}) ? screen_height_ff
                                                          : y_sum_in[XY_W-1:0];
      y_clear_in  = y_sum_in > {1'b0, screen_height_ff};
      y_eff_in    = y_clear_in ? '0 : cursor_y_ff;
      rows_lim_in = (glyph_height_ff > GH_W'(MAX_GLYPH_ROWS)) ? ROWS_W'(MAX_GLYPH_ROWS)
                                                            : ROWS_W'(glyph_height_ff);
      fits_in     = !wrap_in && (({1'b0, y_eff_in} + (XY_W+1)'(rows_lim_in))
                                 <= {1'b0, screen_height_ff});
      x_adv_in    = (x_plus_in > (XY_W+1)'(XY_MAX)) ? XY_MAX : x_plus_in[XY_W-1:0];
      off_in      = OFF_W'(cursor_y_ff * scanline_bytes_ff)
                    + OFF_W'({cursor_x_ff, 2'b00});
      base_in     = FULL_W'(code_ff) * FULL_W'(glyph_height_ff);
      last_row_in = (row_ff + ROWS_W'(1)) == rows_ff;
      row_in      = (state_ff == ST_ROWS && out_free) ? row_ff + ROWS_W'(1) : row_ff;
      rd_full_in  = base_ff + FULL_W'(row_in);
      oor_in      = rd_full_in >= FULL_W'(FONT_BYTES);
      rd_addr     = rd_full_in[AW-1:0];
      bits_in     = oor_ff ? '0 : rd_data;
      wr_full     = FULL_W'(req_font_addr);
      wr_en       = req_accept && req_mode && (wr_full < FULL_W'(FONT_BYTES));
   end

   tcgr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FONT_BYTES)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_full[AW-1:0]),
      .wr_data (req_font_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      oor_ff <= oor_in;
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         cursor_x_ff       <= '0;
         cursor_y_ff       <= '0;
         screen_width_ff   <= WIDTH_RST;
         screen_height_ff  <= HEIGHT_RST;
         scanline_bytes_ff <= SCAN_RST;
         glyph_height_ff   <= GH_RST;
         fg_color_ff       <= FG_RST;
         bg_color_ff       <= BG_RST;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_wr_data[XY_W-1:0];
               CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_wr_data[XY_W-1:0];
               CSR_SCANLINE_BYTES: scanline_bytes_ff <= csr_wr_data[SCAN_W-1:0];
               CSR_GLYPH_HEIGHT:   glyph_height_ff   <= csr_wr_data[GH_W-1:0];
               CSR_FG_COLOR:       fg_color_ff       <= csr_wr_data[COLOR_W-1:0];
               CSR_BG_COLOR:       bg_color_ff       <= csr_wr_data[COLOR_W-1:0];
               default: ;
            endcase
         end

         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && !req_mode) begin
                  unique case (req_char_code)
                     CHAR_NUL: ;
                     CHAR_CR: begin
                        cursor_x_ff <= '0;
                     end
                     CHAR_BS: begin
                        cursor_x_ff <= (cursor_x_ff >= XY_W'(CELL_W))
                                       ? cursor_x_ff - XY_W'(CELL_W) : '0;
                     end
                     CHAR_LF: begin
                        cursor_x_ff <= '0;
                        cursor_y_ff <= y_down_in;
                     end
                     default: begin
                        if (wrap_in) begin
                           cursor_x_ff <= '0;
                           cursor_y_ff <= y_down_in;
                        end
                        code_ff  <= req_char_code;
                        state_ff <= ST_PREP;
                     end
                  endcase
               end
            end
            ST_PREP: begin
               clear_ff    <= y_clear_in;
               cursor_y_ff <= y_eff_in;
               rows_ff     <= fits_in ? rows_lim_in : '0;
               state_ff    <= ST_MUL;
            end
            ST_MUL: begin
               off_ff      <= off_in;
               base_ff     <= base_in;
               row_ff      <= '0;
               cursor_x_ff <= x_adv_in;
               if (clear_ff) begin
                  state_ff <= ST_CLEAR;
               end else if (rows_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_ROWS;
            end
            ST_CLEAR: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_clear_ff  <= 1'b1;
                  rsp_offset_ff <= '0;
                  rsp_pix01_ff  <= '0;
                  rsp_pix23_ff  <= '0;
                  rsp_pix45_ff  <= '0;
                  rsp_pix67_ff  <= '0;
                  rsp_last_ff   <= (rows_ff == '0);
                  state_ff      <= (rows_ff == '0) ? ST_IDLE : ST_ROWS;
               end
            end
            ST_ROWS: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_clear_ff  <= 1'b0;
                  rsp_offset_ff <= off_ff;
                  rsp_pix01_ff  <= pixel_pair(bits_in[7], bits_in[6], fg_color_ff, bg_color_ff);
                  rsp_pix23_ff  <= pixel_pair(bits_in[5], bits_in[4], fg_color_ff, bg_color_ff);
                  rsp_pix45_ff  <= pixel_pair(bits_in[3], bits_in[2], fg_color_ff, bg_color_ff);
                  rsp_pix67_ff  <= pixel_pair(bits_in[1], bits_in[0], fg_color_ff, bg_color_ff);
                  rsp_last_ff   <= last_row_in;
                  off_ff        <= off_ff + OFF_W'(scanline_bytes_ff);
                  row_ff        <= row_in;
                  if (last_row_in) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clear_screen = rsp_clear_ff;
   assign rsp_row_offset   = rsp_offset_ff;
   assign rsp_pixels_01    = rsp_pix01_ff;
   assign rsp_pixels_23    = rsp_pix23_ff;
   assign rsp_pixels_45    = rsp_pix45_ff;
   assign rsp_pixels_67    = rsp_pix67_ff;
   assign rsp_last         = rsp_last_ff;

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS) |-> (row_ff < rows_ff))
      else $error("row index beyond the glyph row count");

   a_clear_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clear_screen) |->
         (rsp_row_offset == '0 && rsp_pixels_01 == '0 && rsp_pixels_23 == '0
          && rsp_pixels_45 == '0 && rsp_pixels_67 == '0))
      else $error("clear-screen transfer carries nonzero payload");

   a_last_row_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS && out_free && last_row_in) |=>
         (state_ff == ST_IDLE && rsp_valid && rsp_last))
      else $error("final glyph row did not end the character");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("font write while a character is in work");

endmodule

@@ sim/text_console_glyph_renderer_unit_test.sv @@
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Loads the whole font store, then drives control codes, edge wraps,
// clear-screen cases, tall and short glyphs and random character traffic
// through the renderer under several register settings. An internal model
// of the console predicts every row transfer, and each response is checked
// in order against it while both channels idle at random, including one
// long response hold-off.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit_test;
   import tcgr_pkg::*;

   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam logic [CODE_W-1:0] CHAR_FIRST_GLYPH = 8'h01;
   localparam logic [CODE_W-1:0] CHAR_LAST_GLYPH  = 8'hFF;

   typedef struct packed {
      logic             clear;
      logic [OFF_W-1:0] offset;
      logic [PIX_W-1:0] p01;
      logic [PIX_W-1:0] p23;
      logic [PIX_W-1:0] p45;
      logic [PIX_W-1:0] p67;
      logic             last;
   } glyph_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = 1'b0;
   logic [CODE_W-1:0]     req_char_code = '0;
   logic [FADDR_W-1:0]    req_font_addr = '0;
   logic [BYTE_W-1:0]     req_font_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_clear_screen;
   logic [OFF_W-1:0]      rsp_row_offset;
   logic [PIX_W-1:0]      rsp_pixels_01;
   logic [PIX_W-1:0]      rsp_pixels_23;
   logic [PIX_W-1:0]      rsp_pixels_45;
   logic [PIX_W-1:0]      rsp_pixels_67;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   bit idle_enable = 1'b1;
   bit hold_request = 1'b0;

   logic [XY_W-1:0]    cfg_width;
   logic [XY_W-1:0]    cfg_height;
   logic [SCAN_W-1:0]  cfg_scan;
   logic [GH_W-1:0]    cfg_rows;
   logic [COLOR_W-1:0] cfg_fg;
   logic [COLOR_W-1:0] cfg_bg;
   logic [XY_W-1:0]    cur_x;
   logic [XY_W-1:0]    cur_y;
   logic [BYTE_W-1:0]  font_mem [0:FONT_BYTES_DEF-1];

   glyph_row_t pending_rows [$];

   int mismatch_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int clear_count = 0;
   int config_count = 0;
   int quiet_cycles = 0;

   text_console_glyph_renderer_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_font_addr(req_font_addr),
      .req_font_byte(req_font_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_clear_screen(rsp_clear_screen),
      .rsp_row_offset(rsp_row_offset),
      .rsp_pixels_01(rsp_pixels_01),
      .rsp_pixels_23(rsp_pixels_23),
      .rsp_pixels_45(rsp_pixels_45),
      .rsp_pixels_67(rsp_pixels_67),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [COLOR_W-1:0] glyph_color(input logic [BYTE_W-1:0] bits,
                                                      input int pixel);
      return bits[7 - pixel] ? cfg_fg : cfg_bg;
   endfunction

   function automatic int unsigned next_line(input int unsigned y);
      int unsigned ny;
      ny = y + LINE_H;
      if (ny > cfg_height) ny = cfg_height;
      return ny & XY_MAX;
   endfunction

   task automatic queue_row(input logic clear, input longint unsigned offset,
                            input logic [BYTE_W-1:0] bits, input logic last);
      glyph_row_t row;
      row.clear  = clear;
      row.offset = clear ? '0 : offset[OFF_W-1:0];
      row.p01    = clear ? '0 : {glyph_color(bits, 1), glyph_color(bits, 0)};
      row.p23    = clear ? '0 : {glyph_color(bits, 3), glyph_color(bits, 2)};
      row.p45    = clear ? '0 : {glyph_color(bits, 5), glyph_color(bits, 4)};
      row.p67    = clear ? '0 : {glyph_color(bits, 7), glyph_color(bits, 6)};
      row.last   = last;
      pending_rows.push_back(row);
   endtask

   task automatic reset_console();
      int a;
      cfg_width  = WIDTH_RST;
      cfg_height = HEIGHT_RST;
      cfg_scan   = SCAN_RST;
      cfg_rows   = GH_RST;
      cfg_fg     = FG_RST;
      cfg_bg     = BG_RST;
      cur_x      = '0;
      cur_y      = '0;
      for (a = 0; a < FONT_BYTES_DEF; a++) font_mem[a] = '0;
   endtask

   task automatic advance_console(input logic mode, input logic [CODE_W-1:0] code,
                                  input logic [FADDR_W-1:0] addr,
                                  input logic [BYTE_W-1:0] fbyte);
      int unsigned x;
      int unsigned y;
      int unsigned rows;
      int unsigned r;
      int unsigned a;
      logic cleared;
      logic [BYTE_W-1:0] bits;
      longint unsigned offset;
      x = cur_x;
      y = cur_y;
      cleared = 1'b0;
      if (mode) begin
         if (addr < FONT_BYTES_DEF) font_mem[addr] = fbyte;
      end else if (code == CHAR_NUL) begin
      end else if (code == CHAR_CR) begin
         x = 0;
      end else if (code == CHAR_BS) begin
         x = (x >= CELL_W) ? x - CELL_W : 0;
      end else if (code == CHAR_LF) begin
         x = 0;
         y = next_line(y);
      end else begin
         if (x + CELL_W > cfg_width) begin
            x = 0;
            y = next_line(y);
         end
         if (y + LINE_H > cfg_height) begin
            y = 0;
            cleared = 1'b1;
         end
         rows = (cfg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cfg_rows;
         if (!((x + CELL_W <= cfg_width) && (y + rows <= cfg_height))) rows = 0;
         if (cleared) queue_row(1'b1, 0, '0, rows == 0);
         for (r = 0; r < rows; r++) begin
            a = code * cfg_rows + r;
            bits = (a < FONT_BYTES_DEF) ? font_mem[a] : '0;
            offset = longint'(y + r) * cfg_scan + longint'(x) * 4;
            queue_row(1'b0, offset, bits, r + 1 == rows);
         end
         x = x + CELL_W;
         if (x > XY_MAX) x = XY_MAX;
      end
      cur_x = x;
      cur_y = y;
   endtask

   task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
                               input logic [FADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] fbyte);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_char_code <= code;
      req_font_addr <= addr;
      req_font_byte <= fbyte;
      do @(posedge clock); while (req_stall);
      advance_console(mode, code, addr, fbyte);
      req_count++;
   endtask

   task automatic print_char(input logic [CODE_W-1:0] code);
      send_request(1'b0, code, $urandom_range(0, FONT_BYTES_DEF - 1), $urandom_range(0, 255));
   endtask

   task automatic send_random_request();
      int unsigned pick;
      logic [CODE_W-1:0] code;
      pick = $urandom_range(0, 99);
      code = $urandom_range(0, 255);
      if (pick < 10) begin
         send_request(1'b1, code, $urandom_range(0, FONT_BYTES_DEF - 1), $urandom_range(0, 255));
      end else begin
         if (pick < 22) begin
            case ($urandom_range(0, 3))
               0: code = CHAR_NUL;
               1: code = CHAR_CR;
               2: code = CHAR_BS;
               default: code = CHAR_LF;
            endcase
         end
         print_char(code);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned width, height, scan, rows,
                               input logic [COLOR_W-1:0] fg, bg);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SCREEN_WIDTH;
      csr_wr_data <= width;
      @(posedge clock);
      csr_index   <= CSR_SCREEN_HEIGHT;
      csr_wr_data <= height;
      @(posedge clock);
      csr_index   <= CSR_SCANLINE_BYTES;
      csr_wr_data <= scan;
      @(posedge clock);
      csr_index   <= CSR_GLYPH_HEIGHT;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_index   <= CSR_FG_COLOR;
      csr_wr_data <= fg;
      @(posedge clock);
      csr_index   <= CSR_BG_COLOR;
      csr_wr_data <= bg;
      @(posedge clock);
      csr_index   <= config_count[0] ? CSR_SPARE_B : CSR_SPARE_A;
      csr_wr_data <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_width  = width;
      cfg_height = height;
      cfg_scan   = scan;
      cfg_rows   = rows;
      cfg_fg     = fg;
      cfg_bg     = bg;
      config_count++;
   endtask

   task automatic apply_random_config();
      if ($urandom_range(0, 3) == 0) begin
         apply_config($urandom_range(8, 4096), $urandom_range(16, 4096),
                      $urandom_range(32, 16384), $urandom_range(1, 32), $urandom, $urandom);
      end else begin
         apply_config($urandom_range(8, 96), $urandom_range(16, 128),
                      $urandom_range(32, 16384), $urandom_range(1, 32), $urandom, $urandom);
      end
   endtask

   task automatic test_font_load();
      int a;
      for (a = 0; a < FONT_BYTES_DEF; a++) begin
         send_request(1'b1, $urandom_range(0, 255), a, $urandom_range(0, 255));
      end
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 0, 8'hFF);
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 1, 8'h00);
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 2, 8'h80);
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 3, 8'h01);
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 4, 8'hAA);
      send_request(1'b1, CHAR_NUL, CHAR_FIRST_GLYPH * LINE_H + 5, 8'h55);
      wait_idle();
   endtask

   task automatic test_control_codes();
      print_char(CHAR_FIRST_GLYPH);
      print_char(CHAR_LAST_GLYPH);
      print_char(CHAR_BS);
      print_char(CHAR_BS);
      print_char(CHAR_BS);
      print_char(CHAR_FIRST_GLYPH);
      print_char(CHAR_CR);
      print_char(CHAR_NUL);
      print_char(CHAR_LF);
      print_char(CHAR_FIRST_GLYPH);
      wait_idle();
   endtask

   task automatic test_screen_edges();
      apply_config(8, 16, 32, 16, 32'h0000_0000, 32'hFFFF_FFFF);
      print_char(CHAR_FIRST_GLYPH);
      print_char(CHAR_FIRST_GLYPH);
      print_char(CHAR_LF);
      print_char(CHAR_LF);
      print_char(CHAR_LAST_GLYPH);
      wait_idle();
      apply_config(8, 16, 32, 32, 32'hFFFF_FFFF, 32'h0000_0000);
      print_char(CHAR_FIRST_GLYPH);
      print_char(CHAR_FIRST_GLYPH);
      wait_idle();
      apply_config(4096, 4096, 16384, 1, $urandom, $urandom);
      print_char(CHAR_LAST_GLYPH);
      print_char(CHAR_FIRST_GLYPH);
      wait_idle();
   endtask

   task automatic test_tall_screen();
      int i;
      apply_config(4096, 4096, 16384, 32, $urandom, $urandom);
      for (i = 0; i < 254; i++) print_char(CHAR_LF);
      for (i = 0; i < 20; i++) send_random_request();
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int phase;
      int i;
      for (phase = 0; phase < 5; phase++) begin
         apply_random_config();
         for (i = 0; i < 50; i++) send_random_request();
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      int i;
      apply_config(WIDTH_RST, HEIGHT_RST, SCAN_RST, GH_RST, $urandom, $urandom);
      hold_request = 1'b1;
      for (i = 0; i < 30; i++) print_char($urandom_range(14, 255));
      wait_idle();
   endtask

   task automatic test_steady_stream();
      int i;
      idle_enable = 1'b0;
      apply_random_config();
      for (i = 0; i < 60; i++) send_random_request();
      wait_idle();
   endtask

   initial begin : rsp_stall_driver
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_checker
      glyph_row_t want;
      glyph_row_t got;
      if (rsp_valid && !rsp_stall) begin
         got = {rsp_clear_screen, rsp_row_offset, rsp_pixels_01, rsp_pixels_23,
                rsp_pixels_45, rsp_pixels_67, rsp_last};
         rsp_count++;
         if (pending_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("ERROR: response %0d arrived with none expected", rsp_count);
               $display("  actual   clr=%b off=%h px=%h %h %h %h last=%b", got.clear,
                        got.offset, got.p01, got.p23, got.p45, got.p67, got.last);
            end
         end else begin
            want = pending_rows.pop_front();
            if (want.clear) clear_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("ERROR: response %0d differs", rsp_count);
                  $display("  expected clr=%b off=%h px=%h %h %h %h last=%b", want.clear,
                           want.offset, want.p01, want.p23, want.p45, want.p67, want.last);
                  $display("  actual   clr=%b off=%h px=%h %h %h %h last=%b", got.clear,
                           got.offset, got.p01, got.p23, got.p45, got.p67, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_console();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_font_load();
      test_control_codes();
      test_screen_edges();
      test_tall_screen();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();
      $display("Sent %0d requests and checked %0d responses (%0d clear-screen) under %0d settings.",
               req_count, rsp_count, clear_count, config_count);
      $display("Run covered control codes, edge wraps, tall glyphs, random traffic and a long hold.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
